// ===== rtl/core/msasm_pkg.sv =====
// ----------------------------------------------------------------------------
// msasm_pkg: shared types and helpers for the matrix slice engine
// Item structs, opcode and register codes, controller state type,
// command/status bundles and single-precision rounding helpers.
// ----------------------------------------------------------------------------
package msasm_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  src_row;
		logic [3:0]  src_col;
		logic [31:0] element;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic [31:0] out_value;
		logic        last;
	} result_t;

	localparam logic [1:0] OPC_LOAD_L = 2'd0;
	localparam logic [1:0] OPC_LOAD_R = 2'd1;
	localparam logic [1:0] OPC_START  = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [2:0] REG_OPERATION = 3'd0;
	localparam logic [2:0] REG_ROWS      = 3'd1;
	localparam logic [2:0] REG_COLS      = 3'd2;
	localparam logic [2:0] REG_L_ROW     = 3'd3;
	localparam logic [2:0] REG_L_COL     = 3'd4;
	localparam logic [2:0] REG_R_ROW     = 3'd5;
	localparam logic [2:0] REG_R_COL     = 3'd6;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_KICK,
		ST_MUL,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       add_go;
		logic       mul_go;
		logic       acc_clr;
		logic       emit;
		logic       last;
		logic [2:0] i;
		logic [2:0] j;
		logic [2:0] k;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] rows;
		logic [3:0] cols;
		logic       mul_done;
		logic       add_done;
	} status_t;

	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int b = 47; b >= 0; b--) begin
			if (!found && v[b]) begin
				n = 6'(47 - b);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// e is the biased exponent; m[23] clear marks a subnormal
	function automatic logic [31:0] round_pack(input logic sign, input logic [9:0] e,
			input logic [23:0] m, input logic g, input logic st);
		logic [7:0]  field;
		logic [30:0] body;
		logic        inc;
		field = m[23] ? e[7:0] : 8'd0;
		body = {field, m[22:0]};
		inc = g & (st | m[0]);
		if (e >= 10'd255)
			return {sign, 8'hFF, 23'd0};
		return {sign, body + 31'(inc)};
	endfunction

endpackage

// ===== rtl/core/msasm_ram.sv =====
// ----------------------------------------------------------------------------
// msasm_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msasm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/msasm_fmul.sv =====
// ----------------------------------------------------------------------------
// msasm_fmul: single-precision multiplier
// Five-stage pipeline: product, leading-zero count, normalize,
// subnormal shift, round and pack. Round to nearest even.
// ----------------------------------------------------------------------------
module msasm_fmul
	import msasm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] res
);

	logic [4:0] vld_q;

	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
	logic [7:0] ea_eff, eb_eff;
	logic [23:0] ma, mb;
	logic spec;
	logic [31:0] spec_val;

	logic               sgn_s1, spec_s1;
	logic [31:0]        spec_val_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] exp_s1;

	logic               sgn_s2, spec_s2;
	logic [31:0]        spec_val_s2;
	logic [47:0]        prod_s2;
	logic signed [10:0] exp_s2;
	logic [5:0]         lz_s2;

	logic               sgn_s3, spec_s3;
	logic [31:0]        spec_val_s3;
	logic [47:0]        norm_s3;
	logic signed [10:0] exp_s3;
	logic [5:0]         rs_s3;
	logic signed [10:0] e_norm, rs_full;

	logic               sgn_s4, spec_s4;
	logic [31:0]        spec_val_s4;
	logic [23:0]        m_s4;
	logic               g_s4, st_s4;
	logic [9:0]         e_s4;
	logic [95:0]        ext;

	logic [31:0] res_q;

	always_comb begin
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		sgn = a[31] ^ b[31];
		ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		spec = 1'b1;
		if (a_nan)
			spec_val = a | QUIET_BIT;
		else if (b_nan)
			spec_val = b | QUIET_BIT;
		else if ((a_inf && b_zero) || (b_inf && a_zero))
			spec_val = QNAN_DEFAULT;
		else if (a_inf || b_inf)
			spec_val = {sgn, 8'hFF, 23'd0};
		else if (a_zero || b_zero)
			spec_val = {sgn, 31'd0};
		else begin
			spec = 1'b0;
			spec_val = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], go};
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1 <= sgn;
		spec_s1 <= spec;
		spec_val_s1 <= spec_val;
		prod_s1 <= ma * mb;
		exp_s1 <= $signed({3'd0, ea_eff}) + $signed({3'd0, eb_eff}) - 11'sd126;
	end

	always_ff @(posedge clk) begin
		sgn_s2 <= sgn_s1;
		spec_s2 <= spec_s1;
		spec_val_s2 <= spec_val_s1;
		prod_s2 <= prod_s1;
		exp_s2 <= exp_s1;
		lz_s2 <= clz48(prod_s1);
	end

	always_comb begin
		e_norm = exp_s2 - $signed({5'd0, lz_s2});
		rs_full = 11'sd1 - e_norm;
	end

	always_ff @(posedge clk) begin
		sgn_s3 <= sgn_s2;
		spec_s3 <= spec_s2;
		spec_val_s3 <= spec_val_s2;
		norm_s3 <= prod_s2 << lz_s2;
		exp_s3 <= e_norm;
		if (e_norm >= 11'sd1)
			rs_s3 <= 6'd0;
		else if (rs_full > 11'sd63)
			rs_s3 <= 6'd63;
		else
			rs_s3 <= rs_full[5:0];
	end

	assign ext = {norm_s3, 48'd0} >> rs_s3;

	always_ff @(posedge clk) begin
		sgn_s4 <= sgn_s3;
		spec_s4 <= spec_s3;
		spec_val_s4 <= spec_val_s3;
		m_s4 <= ext[95:72];
		g_s4 <= ext[71];
		st_s4 <= |ext[70:0];
		if (exp_s3 < 11'sd1)
			e_s4 <= 10'd0;
		else if (exp_s3 > 11'sd255)
			e_s4 <= 10'd255;
		else
			e_s4 <= exp_s3[9:0];
	end

	always_ff @(posedge clk) begin
		res_q <= spec_s4 ? spec_val_s4 : round_pack(sgn_s4, e_s4, m_s4, g_s4, st_s4);
	end

	assign done = vld_q[4];
	assign res = res_q;

endmodule

// ===== rtl/core/msasm_fadd.sv =====
// ----------------------------------------------------------------------------
// msasm_fadd: single-precision adder / subtractor
// Six-stage pipeline: compare and swap, align, add, leading-zero count,
// normalize, round and pack. Round to nearest even.
// ----------------------------------------------------------------------------
module msasm_fadd
	import msasm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic        sub,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] res
);

	logic [5:0] vld_q;

	logic a_nan, b_nan, a_inf, b_inf, sb, a_ge, spec;
	logic [31:0] spec_val, bx, big, sml;
	logic [7:0] big_e, sml_e;

	logic        spec_s1, sgn_s1, esub_s1;
	logic [31:0] spec_val_s1;
	logic [7:0]  e_s1, diff_s1;
	logic [23:0] bm_s1, sm_s1;

	logic [4:0]  dcap;
	logic [50:0] wide;

	logic        spec_s2, sgn_s2, esub_s2;
	logic [31:0] spec_val_s2;
	logic [7:0]  e_s2;
	logic [26:0] bm_s2, al_s2;

	logic        spec_s3, sgn_s3, esub_s3;
	logic [31:0] spec_val_s3;
	logic [7:0]  e_s3;
	logic [27:0] sum_s3;

	logic        spec_s4, sgn_s4, esub_s4;
	logic [31:0] spec_val_s4;
	logic [7:0]  e_s4;
	logic [27:0] sum_s4;
	logic [5:0]  lz_s4;

	logic [7:0]  sh;
	logic [26:0] n27;
	logic [8:0]  e_n;

	logic        spec_s5, sgn_s5, zero_s5, zsgn_s5, g_s5, st_s5;
	logic [31:0] spec_val_s5;
	logic [8:0]  e_s5;
	logic [23:0] m_s5;

	logic [31:0] res_q;

	always_comb begin
		sb = b[31] ^ sub;
		bx = {sb, b[30:0]};
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		spec = 1'b1;
		if (a_nan)
			spec_val = a | QUIET_BIT;
		else if (b_nan)
			spec_val = b | QUIET_BIT;
		else if (a_inf && b_inf && (a[31] != sb))
			spec_val = QNAN_DEFAULT;
		else if (a_inf)
			spec_val = a;
		else if (b_inf)
			spec_val = bx;
		else begin
			spec = 1'b0;
			spec_val = 32'd0;
		end
		a_ge = a[30:0] >= b[30:0];
		big = a_ge ? a : bx;
		sml = a_ge ? bx : a;
		big_e = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		sml_e = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], go};
		end
	end

	always_ff @(posedge clk) begin
		spec_s1 <= spec;
		spec_val_s1 <= spec_val;
		sgn_s1 <= big[31];
		esub_s1 <= big[31] ^ sml[31];
		e_s1 <= big_e;
		diff_s1 <= big_e - sml_e;
		bm_s1 <= {big[30:23] != 8'd0, big[22:0]};
		sm_s1 <= {sml[30:23] != 8'd0, sml[22:0]};
	end

	// align the smaller operand, fold shifted-out bits into sticky
	always_comb begin
		dcap = (diff_s1 > 8'd31) ? 5'd31 : diff_s1[4:0];
		wide = {sm_s1, 27'd0} >> dcap;
	end

	always_ff @(posedge clk) begin
		spec_s2 <= spec_s1;
		spec_val_s2 <= spec_val_s1;
		sgn_s2 <= sgn_s1;
		esub_s2 <= esub_s1;
		e_s2 <= e_s1;
		bm_s2 <= {bm_s1, 3'd0};
		al_s2 <= {wide[50:25], wide[24] | (|wide[23:0])};
	end

	always_ff @(posedge clk) begin
		spec_s3 <= spec_s2;
		spec_val_s3 <= spec_val_s2;
		sgn_s3 <= sgn_s2;
		esub_s3 <= esub_s2;
		e_s3 <= e_s2;
		sum_s3 <= esub_s2 ? ({1'b0, bm_s2} - {1'b0, al_s2}) : ({1'b0, bm_s2} + {1'b0, al_s2});
	end

	always_ff @(posedge clk) begin
		spec_s4 <= spec_s3;
		spec_val_s4 <= spec_val_s3;
		sgn_s4 <= sgn_s3;
		esub_s4 <= esub_s3;
		e_s4 <= e_s3;
		sum_s4 <= sum_s3;
		lz_s4 <= clz48({sum_s3, 20'd0});
	end

	// normalize; stop the left shift at the subnormal boundary
	always_comb begin
		sh = {2'd0, lz_s4} - 8'd1;
		if (sh > e_s4 - 8'd1)
			sh = e_s4 - 8'd1;
		if (sum_s4[27]) begin
			n27 = {sum_s4[27:2], sum_s4[1] | sum_s4[0]};
			e_n = {1'b0, e_s4} + 9'd1;
		end else begin
			n27 = sum_s4[26:0] << sh;
			e_n = {1'b0, e_s4 - sh};
		end
	end

	always_ff @(posedge clk) begin
		spec_s5 <= spec_s4;
		spec_val_s5 <= spec_val_s4;
		sgn_s5 <= sgn_s4;
		zero_s5 <= (sum_s4 == 28'd0);
		zsgn_s5 <= esub_s4 ? 1'b0 : sgn_s4;
		e_s5 <= e_n;
		m_s5 <= n27[26:3];
		g_s5 <= n27[2];
		st_s5 <= |n27[1:0];
	end

	always_ff @(posedge clk) begin
		if (spec_s5)
			res_q <= spec_val_s5;
		else if (zero_s5)
			res_q <= {zsgn_s5, 31'd0};
		else
			res_q <= round_pack(sgn_s5, {1'b0, e_s5}, m_s5, g_s5, st_s5);
	end

	assign done = vld_q[5];
	assign res = res_q;

endmodule

// ===== rtl/core/msasm_dp.sv =====
// ----------------------------------------------------------------------------
// msasm_dp: datapath
// Configuration registers, source stores, window address generation,
// float units, accumulator and the result register.
// ----------------------------------------------------------------------------
module msasm_dp
	import msasm_pkg::*;
#(
	parameter int SRC_DIM   = 16,
	parameter int MAX_SLICE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  in_item_t   item,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  cmd_t       cmd,
	output status_t    status,
	output result_t    result,
	output logic       strobe
);

	localparam int DEPTH = SRC_DIM * SRC_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(SRC_DIM);

	logic [1:0] operation_q;
	logic [3:0] rows_q, cols_q, l_row_q, l_col_q, r_row_q, r_col_q;
	logic [3:0] rows_c, cols_c;

	logic [RW-1:0] wrap_lut [32];

	logic [AW-1:0] waddr, l_raddr, r_raddr;
	logic [31:0]   l_rd, r_rd;
	logic          l_we, r_we, is_mul;
	logic [2:0]    l_col_i, r_row_i;

	logic        mul_done, add_done;
	logic [31:0] mul_res, add_res, acc_q;
	result_t     result_q;
	logic        strobe_q;

	for (genvar g = 0; g < 32; g++) begin : g_wrap
		assign wrap_lut[g] = RW'(g % SRC_DIM);
	end

	function automatic logic [3:0] clamp_size(input logic [3:0] v);
		if (v == 4'd0)
			return 4'd1;
		if (v > 4'(MAX_SLICE))
			return 4'(MAX_SLICE);
		return v;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
		return AW'(AW'(r) * AW'(SRC_DIM) + AW'(c));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q <= OP_ADD;
			rows_q <= 4'd1;
			cols_q <= 4'd1;
			l_row_q <= 4'd0;
			l_col_q <= 4'd0;
			r_row_q <= 4'd0;
			r_col_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPERATION: operation_q <= cfg_data[1:0];
				REG_ROWS:      rows_q <= cfg_data;
				REG_COLS:      cols_q <= cfg_data;
				REG_L_ROW:     l_row_q <= cfg_data;
				REG_L_COL:     l_col_q <= cfg_data;
				REG_R_ROW:     r_row_q <= cfg_data;
				REG_R_COL:     r_col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_mul = (operation_q == OP_MUL);
		rows_c = clamp_size(rows_q);
		cols_c = is_mul ? rows_c : clamp_size(cols_q);
		l_we = accept && (item.opcode == OPC_LOAD_L);
		r_we = accept && (item.opcode == OPC_LOAD_R);
		waddr = addr_of(wrap_lut[{1'b0, item.src_row}], wrap_lut[{1'b0, item.src_col}]);
		// multiply walks k along the left row and down the right column
		l_col_i = is_mul ? cmd.k : cmd.j;
		r_row_i = is_mul ? cmd.k : cmd.i;
		l_raddr = addr_of(wrap_lut[5'(l_row_q) + 5'(cmd.i)], wrap_lut[5'(l_col_q) + 5'(l_col_i)]);
		r_raddr = addr_of(wrap_lut[5'(r_row_q) + 5'(r_row_i)], wrap_lut[5'(r_col_q) + 5'(cmd.j)]);
	end

	msasm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_left (
		.clk(clk), .we(l_we), .waddr(waddr), .wdata(item.element),
		.raddr(l_raddr), .rdata(l_rd)
	);

	msasm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_right (
		.clk(clk), .we(r_we), .waddr(waddr), .wdata(item.element),
		.raddr(r_raddr), .rdata(r_rd)
	);

	msasm_fmul u_fmul (
		.clk(clk), .arst_n(arst_n), .go(cmd.mul_go), .a(l_rd), .b(r_rd),
		.done(mul_done), .res(mul_res)
	);

	msasm_fadd u_fadd (
		.clk(clk), .arst_n(arst_n), .go(cmd.add_go), .sub(operation_q == OP_SUB),
		.a(is_mul ? acc_q : l_rd), .b(is_mul ? mul_res : r_rd),
		.done(add_done), .res(add_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc_clr)
			acc_q <= 32'd0;
		else if (add_done)
			acc_q <= add_res;
		if (cmd.emit) begin
			result_q.out_row <= cmd.i;
			result_q.out_col <= cmd.j;
			result_q.out_value <= acc_q;
			result_q.last <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_comb begin
		status.op = operation_q;
		status.rows = rows_c;
		status.cols = cols_c;
		status.mul_done = mul_done;
		status.add_done = add_done;
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

// ===== rtl/core/msasm_ctrl.sv =====
// ----------------------------------------------------------------------------
// msasm_ctrl: sequencer
// Walks the result matrix row by row and, for multiply, the inner
// index k; issues reads, unit starts and result emits.
// ----------------------------------------------------------------------------
module msasm_ctrl
	import msasm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] opcode,
	input  status_t    status,
	output cmd_t       cmd,
	output logic       busy
);

	state_t     state_q, state_d;
	logic [2:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic       is_mul, op_ok, last_el, last_k, last_j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= 3'd0;
			j_q <= 3'd0;
			k_q <= 3'd0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

	always_comb begin
		is_mul = (status.op == OP_MUL);
		op_ok = (status.op == OP_ADD) || (status.op == OP_SUB) || is_mul;
		last_j = ({1'b0, j_q} == status.cols - 4'd1);
		last_el = ({1'b0, i_q} == status.rows - 4'd1) && last_j;
		last_k = ({1'b0, k_q} == status.rows - 4'd1);

		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.k = k_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OPC_START) && op_ok) begin
					i_d = 3'd0;
					j_d = 3'd0;
					k_d = 3'd0;
					cmd.acc_clr = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_KICK;
			ST_KICK: begin
				if (is_mul) begin
					cmd.mul_go = 1'b1;
					state_d = ST_MUL;
				end else begin
					cmd.add_go = 1'b1;
					state_d = ST_ADD;
				end
			end
			ST_MUL: begin
				if (status.mul_done) begin
					cmd.add_go = 1'b1;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (status.add_done) begin
					if (is_mul && !last_k) begin
						k_d = k_q + 3'd1;
						state_d = ST_READ;
					end else begin
						k_d = 3'd0;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.last = last_el;
				if (last_el) begin
					state_d = ST_IDLE;
				end else begin
					cmd.acc_clr = 1'b1;
					if (last_j) begin
						j_d = 3'd0;
						i_d = i_q + 3'd1;
					end else begin
						j_d = j_q + 3'd1;
					end
					state_d = ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/matrix_slice_add_sub_mul.sv =====
// ----------------------------------------------------------------------------
// matrix_slice_add_sub_mul: slice add / subtract / multiply engine
// Loads two float source matrices, then computes on configured windows
// and streams the result matrix out in row-major order.
//
//   channel   ports                         handshake
//   -------   ---------------------------   ---------------------------
//   input     start, busy, item             taken when start && !busy
//   result    strobe, result                one cycle per item, no stall
//   config    cfg_we, cfg_index, cfg_data   written when cfg_we is high
//
// A load item is written into its store; busy stays low. A start item
// with a valid operation keeps busy high while the sequencer walks the
// result: per element, add/subtract run read, issue, six adder stages,
// emit; multiply runs read, issue, five multiplier and six adder stages
// per k step, then emit. Each result shows in the cycle after its emit.
// Reset clears control and configuration; the stores hold garbage.
// ----------------------------------------------------------------------------
module matrix_slice_add_sub_mul
	import msasm_pkg::*;
#(
	parameter int SRC_DIM   = 16,
	parameter int MAX_SLICE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       strobe,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [3:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    accept;

	assign accept = start && !busy;

	msasm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .accept(accept), .opcode(item.opcode),
		.status(status), .cmd(cmd), .busy(busy)
	);

	msasm_dp #(.SRC_DIM(SRC_DIM), .MAX_SLICE(MAX_SLICE)) u_dp (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .status(status), .result(result), .strobe(strobe)
	);

	a_strobe_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe outside a compute run");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("result right after the final element");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && result.last))
		else $error("run ended without a final element");

endmodule
